// File: src/tmse_pkg.sv
package tmse_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAP_SCREEN_X = 3'd0,
    REG_MAP_SCREEN_Y = 3'd1,
    REG_MAP_COLUMNS  = 3'd2,
    REG_MAP_ROWS     = 3'd3,
    REG_LAYER_DEPTH  = 3'd4
  } cfg_reg_t;

  // Field widths
  localparam int TILE_ID_W = 16;
  localparam int POS_W     = 16;
  localparam int COUNT_W   = 8;
  localparam int SIZE_W    = COUNT_W + 1;
  localparam int TEX_W     = 8;
  localparam int DEPTH_W   = 3;
  localparam int SEQ_W     = 16;

  // Tiles are 16x16 pixels; texture coordinates keep the low nibble of the sheet column and row
  localparam int TILE_SHIFT = 4;

  // Visible window including a one-tile border
  localparam logic signed [POS_W-1:0] CULL_MIN   = -16'sd16;
  localparam logic signed [POS_W-1:0] CULL_MAX_X = 16'sd320;
  localparam logic signed [POS_W-1:0] CULL_MAX_Y = 16'sd240;

  // Reset values
  localparam logic [COUNT_W-1:0] MAP_COLUMNS_RESET = 8'd16;
  localparam logic [COUNT_W-1:0] MAP_ROWS_RESET    = 8'd16;

  localparam int TILES_PER_SHEET_ROW_DEFAULT = 16;

  typedef struct packed {
    logic signed [POS_W-1:0] map_screen_x;
    logic signed [POS_W-1:0] map_screen_y;
    logic [COUNT_W-1:0]      map_columns;
    logic [COUNT_W-1:0]      map_rows;
    logic [DEPTH_W-1:0]      layer_depth;
  } cfg_t;

  typedef struct packed {
    logic                    emit;
    logic signed [POS_W-1:0] screen_x;
    logic signed [POS_W-1:0] screen_y;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [DEPTH_W-1:0]      depth_slot;
    logic [SEQ_W-1:0]        sprite_number;
    logic                    map_done;
  } result_t;

endpackage

// File: src/tmse_cfg.sv
module tmse_cfg
  import tmse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_screen_x <= '0;
      cfg.map_screen_y <= '0;
      cfg.map_columns  <= MAP_COLUMNS_RESET;
      cfg.map_rows     <= MAP_ROWS_RESET;
      cfg.layer_depth  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAP_SCREEN_X: cfg.map_screen_x <= cfg_data;
        REG_MAP_SCREEN_Y: cfg.map_screen_y <= cfg_data;
        REG_MAP_COLUMNS:  cfg.map_columns  <= cfg_data[COUNT_W-1:0];
        REG_MAP_ROWS:     cfg.map_rows     <= cfg_data[COUNT_W-1:0];
        REG_LAYER_DEPTH:  cfg.layer_depth  <= cfg_data[DEPTH_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

// File: src/tmse_tex_div.sv
module tmse_tex_div
  import tmse_pkg::*;
#(
  parameter int TILES_PER_SHEET_ROW = TILES_PER_SHEET_ROW_DEFAULT
)(
  input  logic [TILE_ID_W-1:0]  tile_id,
  output logic [TILE_SHIFT-1:0] quot_lo
);

  // Exact reciprocal for a 16-bit dividend: ceil(2^(16+l) / d), l = ceil(log2 d)
  localparam int  SHIFT  = TILE_ID_W + $clog2(TILES_PER_SHEET_ROW);
  localparam int  MULT_W = TILE_ID_W + 1;
  localparam int  PROD_W = TILE_ID_W + MULT_W;
  localparam logic [MULT_W-1:0] MULT =
    MULT_W'(((64'd1 << SHIFT) + TILES_PER_SHEET_ROW - 1) / TILES_PER_SHEET_ROW);

  logic [TILE_ID_W-1:0] index;
  logic [PROD_W-1:0]    prod;

  assign index   = tile_id - TILE_ID_W'(1);
  assign prod    = PROD_W'(index) * PROD_W'(MULT);
  assign quot_lo = TILE_SHIFT'(prod >> SHIFT);

endmodule

// File: src/tmse_walker.sv
module tmse_walker
  import tmse_pkg::*;
#(
  parameter int TILES_PER_SHEET_ROW = TILES_PER_SHEET_ROW_DEFAULT
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [TILE_ID_W-1:0]  tile_id,
  input  logic [TILE_SHIFT-1:0] quot_lo,
  input  cfg_t                  cfg,
  output result_t               result
);

  localparam logic [TILE_SHIFT-1:0] DIVISOR_LO = TILE_SHIFT'(TILES_PER_SHEET_ROW);

  logic [COUNT_W-1:0] column_count;
  logic [COUNT_W-1:0] row_count;
  logic [SEQ_W-1:0]   emitted_count;

  logic [COUNT_W-1:0] column_count_next;
  logic [COUNT_W-1:0] row_count_next;
  logic [SEQ_W-1:0]   emitted_count_next;

  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [SIZE_W-1:0]       columns_eff;
  logic [SIZE_W-1:0]       rows_eff;
  logic                    on_screen;
  logic                    emit;
  logic                    last_col;
  logic                    last_row;
  logic                    done;
  logic [TILE_SHIFT-1:0]   index;
  logic [TILE_SHIFT-1:0]   rem_lo;
  logic [2*TILE_SHIFT-1:0] qd_prod;

  always_comb begin
    pos_x = cfg.map_screen_x + POS_W'({column_count, {TILE_SHIFT{1'b0}}});
    pos_y = cfg.map_screen_y + POS_W'({row_count, {TILE_SHIFT{1'b0}}});
    on_screen = !(pos_x < CULL_MIN || pos_x > CULL_MAX_X ||
                  pos_y < CULL_MIN || pos_y > CULL_MAX_Y);
    emit = (tile_id != '0) && on_screen;

    // A size of zero stands for 256
    columns_eff = (cfg.map_columns == '0) ? {1'b1, {COUNT_W{1'b0}}} : {1'b0, cfg.map_columns};
    rows_eff    = (cfg.map_rows == '0) ? {1'b1, {COUNT_W{1'b0}}} : {1'b0, cfg.map_rows};
    last_col = ({1'b0, column_count} + SIZE_W'(1)) >= columns_eff;
    last_row = ({1'b0, row_count} + SIZE_W'(1)) >= rows_eff;
    done     = last_col && last_row;

    // Only the low nibble of the remainder survives the 8-bit truncation
    index   = tile_id[TILE_SHIFT-1:0] - TILE_SHIFT'(1);
    qd_prod = {{TILE_SHIFT{1'b0}}, quot_lo} * {{TILE_SHIFT{1'b0}}, DIVISOR_LO};
    rem_lo  = index - qd_prod[TILE_SHIFT-1:0];
  end

  always_comb begin
    result.emit          = emit;
    result.screen_x      = pos_x;
    result.screen_y      = pos_y;
    result.tex_u         = emit ? {rem_lo, {TILE_SHIFT{1'b0}}} : '0;
    result.tex_v         = emit ? {quot_lo, {TILE_SHIFT{1'b0}}} : '0;
    result.depth_slot    = emit ? cfg.layer_depth : '0;
    result.sprite_number = emit ? emitted_count : '0;
    result.map_done      = done;
  end

  always_comb begin
    column_count_next  = column_count + COUNT_W'(1);
    row_count_next     = row_count;
    emitted_count_next = emit ? emitted_count + SEQ_W'(1) : emitted_count;
    if (done) begin
      column_count_next  = '0;
      row_count_next     = '0;
      emitted_count_next = '0;
    end else if (last_col) begin
      column_count_next = '0;
      row_count_next    = row_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      emitted_count <= '0;
    end else if (step) begin
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule

// File: src/tile_map_sprite_emitter_core.sv
// Tile map sprite emitter. Feed the map's tile entries in row-major order, one item per
// cycle; each item yields exactly one result item saying whether a 16x16 sprite is emitted,
// where it lands on screen (map origin plus 16 pixels per column or row, wrapping at 16
// bits), its texture u/v in a sheet TILES_PER_SHEET_ROW tiles wide, its depth slot and its
// sequence number in the current map pass. Tiles outside -16..320 by -16..240 and empty
// entries (id 0) are not emitted. map_done marks the last tile; the column, row and
// sequence counters then start over. An accepted item passes the input register, the single
// walker stage and the result register; the block takes one item every cycle while out_ready
// is high, and out_ready low stalls the pipe without losing items.
// Write the configuration registers only while no item is in flight.
module tile_map_sprite_emitter_core
  import tmse_pkg::*;
#(
  parameter int TILES_PER_SHEET_ROW = TILES_PER_SHEET_ROW_DEFAULT
)(
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TILE_ID_W-1:0]    tile_id,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    emit,
  output logic signed [POS_W-1:0] screen_x,
  output logic signed [POS_W-1:0] screen_y,
  output logic [TEX_W-1:0]        tex_u,
  output logic [TEX_W-1:0]        tex_v,
  output logic [DEPTH_W-1:0]      depth_slot,
  output logic [SEQ_W-1:0]        sprite_number,
  output logic                    map_done
);

  cfg_t    cfg;
  result_t result;

  // Input register: tile id plus the precomputed low nibble of the sheet row
  logic                  stage_valid;
  logic [TILE_ID_W-1:0]  stage_tile;
  logic [TILE_SHIFT-1:0] stage_quot;
  logic [TILE_SHIFT-1:0] quot_lo;

  logic out_free;
  logic advance;
  logic in_accept;

  // The result register frees when empty or being taken; the input stage then moves on
  assign out_free  = !out_valid || out_ready;
  assign advance   = stage_valid && out_free;
  assign in_ready  = !stage_valid || out_free;
  assign in_accept = in_valid && in_ready;

  tmse_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sheet row of the incoming tile: reciprocal multiply ahead of the input register
  tmse_tex_div #(
    .TILES_PER_SHEET_ROW (TILES_PER_SHEET_ROW)
  ) u_tex_div (
    .tile_id (tile_id),
    .quot_lo (quot_lo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Payload: hold while stalled, load on accept
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_tile <= tile_id;
      stage_quot <= quot_lo;
    end
  end

  // Position, culling, texture and counters; counters advance as the item leaves the stage
  tmse_walker #(
    .TILES_PER_SHEET_ROW (TILES_PER_SHEET_ROW)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .tile_id (stage_tile),
    .quot_lo (stage_quot),
    .cfg     (cfg),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      emit          <= result.emit;
      screen_x      <= result.screen_x;
      screen_y      <= result.screen_y;
      tex_u         <= result.tex_u;
      tex_v         <= result.tex_v;
      depth_slot    <= result.depth_slot;
      sprite_number <= result.sprite_number;
      map_done      <= result.map_done;
    end
  end

endmodule

// File: src/tmse_checker.sv
module tmse_props
  import tmse_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    emit,
  input logic signed [POS_W-1:0] screen_x,
  input logic signed [POS_W-1:0] screen_y,
  input logic [TEX_W-1:0]        tex_u,
  input logic [TEX_W-1:0]        tex_v,
  input logic [DEPTH_W-1:0]      depth_slot,
  input logic [SEQ_W-1:0]        sprite_number,
  input logic                    map_done
);

  // Hold a stalled result item's emit, position, sequence number and map_done unchanged
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(emit) && $stable(screen_x) &&
      $stable(screen_y) && $stable(sprite_number) && $stable(map_done))
    else $error("stalled result item changed");

  // Culled or empty tiles carry zero texture, depth and sequence
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !emit |-> tex_u == '0 && tex_v == '0 && depth_slot == '0 &&
      sprite_number == '0)
    else $error("non-emitted item has sprite fields set");

  // An emitted sprite lies inside the window and on a tile grid in the sheet
  assert property (@(posedge clk) disable iff (rst)
    out_valid && emit |-> screen_x >= CULL_MIN && screen_x <= CULL_MAX_X &&
      screen_y >= CULL_MIN && screen_y <= CULL_MAX_Y &&
      tex_u[TILE_SHIFT-1:0] == '0 && tex_v[TILE_SHIFT-1:0] == '0)
    else $error("emitted sprite outside window or off tile grid");

  // Reset empties the result register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind tile_map_sprite_emitter_core tmse_props u_tmse_props (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .emit          (emit),
  .screen_x      (screen_x),
  .screen_y      (screen_y),
  .tex_u         (tex_u),
  .tex_v         (tex_v),
  .depth_slot    (depth_slot),
  .sprite_number (sprite_number),
  .map_done      (map_done)
);
